[src/skvt_pkg.sv]
// Shared constants, codes and types for the sorted key/value table.
package skvt_pkg;

   localparam int CAPACITY   = 32;
   localparam int KEY_BYTES  = 8;
   localparam int VALUE_BITS = 32;

   localparam int KEY_BITS = 8 * KEY_BYTES;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Port field widths
   localparam int OP_W    = 2;
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int ENTRY_W = 6;

   localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DUP  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   // Broadcast from the control to every cell of the row
   typedef struct packed {
      logic      insert;
      logic      remove;
      logic      replace;
      key_type   key;
      value_type value;
   } cell_ctl_type;

endpackage

[src/skvt_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface skvt_req_if;
   import skvt_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;
   logic               replace_allowed;

   modport source (output valid, op, key, value, replace_allowed, input ready);
   modport sink   (input valid, op, key, value, replace_allowed, output ready);
endinterface

interface skvt_rsp_if;
   import skvt_pkg::*;
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [VALUE_W-1:0] found_value;
   logic [ENTRY_W-1:0] entry_count;

   modport source (output valid, status, found_value, entry_count, input ready);
   modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

[src/sorted_key_value_table.sv]
// Sorted key/value table: top level with request control and the row of cells.
// Keeps up to 32 unique 64-bit keys in ascending order, each with a 32-bit value, in a row of
// cells that each compare their own key with the request key in parallel. A request (find,
// insert, remove) is registered at the accepting edge; the execute edge then compares
// in every cell, applies the one-step shift up or down across the row and loads the response
// register. A new request is taken in the cycle after a response is formed, even while that
// response still waits; execution holds only while the response register is
// full and not being taken. Every response carries the entry count after the request.
module sorted_key_value_table
   import skvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   skvt_req_if.sink    req_chan,
   skvt_rsp_if.source  rsp_chan
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [OP_W-1:0] op_ff;
   key_type         key_ff;
   value_type       value_ff;
   logic            repl_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [VALUE_W-1:0] found_ff, found_in;

   logic accept, go, hit, full;
   value_type hit_val;
   cell_ctl_type ctl;

   key_type   cell_key [CAPACITY];
   value_type cell_val [CAPACITY];
   value_type cell_hv  [CAPACITY];
   logic [CAPACITY-1:0] lt_vec, eq_vec;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign go     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_chan.op;
         key_ff   <= KEY_BITS'(req_chan.key);
         value_ff <= VALUE_BITS'(req_chan.value);
         repl_ff  <= req_chan.replace_allowed;
      end
   end

   // OR across the row; at most one cell can match
   always_comb begin
      hit_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_val = hit_val | cell_hv[i];
      end
   end

   assign hit  = |eq_vec;
   assign full = (count_ff == COUNT_W'(CAPACITY));

   always_comb begin
      ctl.key     = key_ff;
      ctl.value   = value_ff;
      ctl.insert  = go && (op_ff == OP_INSERT) && !hit && !full;
      ctl.remove  = go && (op_ff == OP_REMOVE) && hit;
      ctl.replace = go && (op_ff == OP_INSERT) && hit && repl_ff;
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic      occ, l_lt;
         key_type   l_key, r_key;
         value_type l_val, r_val;

         assign occ = (COUNT_W'(i) < count_ff);
         if (i == 0) begin : g_first
            assign l_lt  = 1'b1;
            assign l_key = cell_key[i];
            assign l_val = cell_val[i];
         end else begin : g_mid
            assign l_lt  = lt_vec[i-1];
            assign l_key = cell_key[i-1];
            assign l_val = cell_val[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign r_key = cell_key[i];
            assign r_val = cell_val[i];
         end else begin : g_inner
            assign r_key = cell_key[i+1];
            assign r_val = cell_val[i+1];
         end

         skvt_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occ),
            .left_lt     (l_lt),
            .left_key    (l_key),
            .left_value  (l_val),
            .right_key   (r_key),
            .right_value (r_val),
            .key_out     (cell_key[i]),
            .value_out   (cell_val[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i]),
            .hit_value   (cell_hv[i])
         );
      end
   endgenerate

   always_comb begin
      status_in = STAT_MISS;
      found_in  = '0;
      count_in  = count_ff;
      case (op_ff)
         OP_FIND: begin
            if (hit) begin
               status_in = STAT_OK;
               found_in  = VALUE_W'(hit_val);
            end
         end
         OP_INSERT: begin
            if (hit) begin
               if (repl_ff) begin
                  status_in = STAT_OK;
                  found_in  = VALUE_W'(hit_val);
               end else begin
                  status_in = STAT_DUP;
               end
            end else if (full) begin
               status_in = STAT_FULL;
            end else begin
               status_in = STAT_OK;
               count_in  = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               status_in = STAT_OK;
               found_in  = VALUE_W'(hit_val);
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = STAT_MISS;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_EXEC;
         S_EXEC:  if (go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.found_value = found_ff;
   assign rsp_chan.entry_count = ENTRY_W'(count_ff);

endmodule

[src/skvt_cell.sv]
// One table cell: holds a key/value pair, compares it and shifts with its neighbours.
module skvt_cell
   import skvt_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,
   input  logic         left_lt,
   input  key_type      left_key,
   input  value_type    left_value,
   input  key_type      right_key,
   input  value_type    right_value,
   output key_type      key_out,
   output value_type    value_out,
   output logic         lt,
   output logic         eq,
   output value_type    hit_value
);

   key_type   key_ff, key_in;
   value_type value_ff, value_in;

   assign lt        = occupied && (key_ff < ctl.key);
   assign eq        = occupied && (key_ff == ctl.key);
   assign hit_value = eq ? value_ff : '0;
   assign key_out   = key_ff;
   assign value_out = value_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.insert) begin
         // cells at or above the insertion point move up; the boundary cell takes the new pair
         if (!lt) begin
            if (left_lt) begin
               key_in   = ctl.key;
               value_in = ctl.value;
            end else begin
               key_in   = left_key;
               value_in = left_value;
            end
         end
      end else if (ctl.remove) begin
         if (!lt) begin
            key_in   = right_key;
            value_in = right_value;
         end
      end else if (ctl.replace && eq) begin
         value_in = ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

[src/skvt_checker.sv]
// Port-level checks for the sorted key/value table, bound to the top level.
module skvt_checker
   import skvt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [VALUE_W-1:0] rsp_found_value,
   input logic [ENTRY_W-1:0] rsp_entry_count
);

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_value) && $stable(rsp_entry_count))
      else $error("response beat changed while stalled");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= ENTRY_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_entry_count == ENTRY_W'(CAPACITY))
      else $error("full status with spare room");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_MISS || rsp_status == STAT_DUP
         || rsp_status == STAT_FULL) |-> rsp_found_value == '0)
      else $error("value returned on a failed request");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_found_value (rsp_chan.found_value),
   .rsp_entry_count (rsp_chan.entry_count)
);

[dv/testbench.sv]
// Self-checking testbench for the sorted key/value table: shadow table, scoreboard, stimulus.
`timescale 1ns / 1ps

module testbench;
   import skvt_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1930;
   localparam int POOL_SIZE    = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 8;

   localparam logic [KEY_W-1:0] KEY_A      = 64'h6100_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_AB     = 64'h6162_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_AC     = 64'h6163_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_A_NUL  = 64'h6100_6200_0000_0000;
   localparam logic [KEY_W-1:0] KEY_TOPBIT = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VALUE_W-1:0] found_value;
      logic [ENTRY_W-1:0] entry_count;
   } answer_type;

   // Shadow of the table contents; predicts each answer and checks it on arrival
   class table_shadow;
      key_type     stored_keys[CAPACITY];
      value_type   stored_values[CAPACITY];
      int unsigned used;
      answer_type  awaited_answers[$];
      int unsigned failures;

      function new();
         used     = 0;
         failures = 0;
      endfunction

      function int unsigned entries();
         return used;
      endfunction

      function int unsigned pending();
         return awaited_answers.size();
      endfunction

      function key_type any_stored_key();
         return stored_keys[$urandom_range(0, used - 1)];
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [VALUE_W-1:0] value, logic replace_allowed);
         answer_type  ans;
         key_type     k;
         value_type   v;
         int unsigned pos;
         int unsigned i;
         bit          hit;
         k = key[KEY_BITS-1:0];
         v = value[VALUE_BITS-1:0];
         ans.status      = STAT_MISS;
         ans.found_value = '0;
         pos = 0;
         while (pos < used && stored_keys[pos] < k) pos++;
         hit = (pos < used) && (stored_keys[pos] == k);
         case (op)
            OP_FIND: begin
               if (hit) begin
                  ans.status      = STAT_OK;
                  ans.found_value = VALUE_W'(stored_values[pos]);
               end
            end
            OP_INSERT: begin
               if (hit) begin
                  if (replace_allowed) begin
                     ans.found_value    = VALUE_W'(stored_values[pos]);
                     stored_values[pos] = v;
                     ans.status         = STAT_OK;
                  end else begin
                     ans.status = STAT_DUP;
                  end
               end else if (used >= CAPACITY) begin
                  ans.status = STAT_FULL;
               end else begin
                  // open a slot at the sorted place
                  for (i = used; i > pos; i--) begin
                     stored_keys[i]   = stored_keys[i-1];
                     stored_values[i] = stored_values[i-1];
                  end
                  stored_keys[pos]   = k;
                  stored_values[pos] = v;
                  used++;
                  ans.status = STAT_OK;
               end
            end
            OP_REMOVE: begin
               if (hit) begin
                  ans.found_value = VALUE_W'(stored_values[pos]);
                  for (i = pos; i + 1 < used; i++) begin
                     stored_keys[i]   = stored_keys[i+1];
                     stored_values[i] = stored_values[i+1];
                  end
                  used--;
                  ans.status = STAT_OK;
               end
            end
            default: ;
         endcase
         ans.entry_count = ENTRY_W'(used);
         awaited_answers.push_back(ans);
      endfunction

      function void check_response(logic [STAT_W-1:0] status, logic [VALUE_W-1:0] found_value,
                                   logic [ENTRY_W-1:0] entry_count);
         answer_type ans;
         if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got status %0d value %h count %0d",
                     $time, status, found_value, entry_count);
            failures++;
            return;
         end
         ans = awaited_answers.pop_front();
         if (status !== ans.status) begin
            $display("%0t: status expected %0d, got %0d", $time, ans.status, status);
            failures++;
         end
         if (found_value !== ans.found_value) begin
            $display("%0t: found_value expected %h, got %h", $time, ans.found_value, found_value);
            failures++;
         end
         if (entry_count !== ans.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d",
                     $time, ans.entry_count, entry_count);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   skvt_req_if req_chan ();
   skvt_rsp_if rsp_chan ();

   sorted_key_value_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   table_shadow      shadow;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];
   bit               steady_send;
   int unsigned      cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // Entered and left at a falling edge; valid stays high across back-to-back beats
   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] value, logic replace_allowed);
      int unsigned gap;
      gap = steady_send ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.op              <= op;
      req_chan.key             <= key;
      req_chan.value           <= value;
      req_chan.replace_allowed <= replace_allowed;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      shadow.note_request(op, key, value, replace_allowed);
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] choose_key(int unsigned stored_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (shadow.entries() != 0 && r < stored_pct) return shadow.any_stored_key();
      if (r < stored_pct + (100 - stored_pct) * 3 / 4)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VALUE_W-1:0] choose_value();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // Response side: random back-pressure with occasional free-flowing stretches
   initial begin
      int unsigned stall;
      int unsigned run_left;
      bit          steady;
      rsp_chan.ready = 1'b0;
      run_left = 0;
      steady   = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (run_left == 0) begin
            steady   = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 60);
         end
         run_left--;
         stall = steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         shadow.check_response(rsp_chan.status, rsp_chan.found_value, rsp_chan.entry_count);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned      n;
      int unsigned      r;
      int unsigned      mode_left;
      int unsigned      stored_pct;
      bit               filling;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] k;

      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.op              = OP_FIND;
      req_chan.key             = '0;
      req_chan.value           = '0;
      req_chan.replace_allowed = 1'b0;
      steady_send              = 1'b0;
      shadow                   = new();

      // Key pool wider than the table, so fill phases run into a full table
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (n = 2; n < POOL_SIZE; n++) begin
         k = {$urandom, $urandom};
         if (n % 3 == 0) k = k << (8 * $urandom_range(1, 7));
         if (n % 3 == 1) k[8 * $urandom_range(1, 6) +: 8] = 8'h00;
         key_pool[n] = k;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table, ends of the key range, zero bytes inside a key, duplicates
      send_request(OP_FIND,   '0,         '1,           1'b1);
      send_request(OP_REMOVE, '0,         '0,           1'b0);
      send_request(OP_UNUSED, '1,         '1,           1'b1);
      send_request(OP_INSERT, '0,         '0,           1'b0);
      send_request(OP_INSERT, '1,         '1,           1'b0);
      send_request(OP_INSERT, KEY_AB,     32'h1234_5678, 1'b0);
      send_request(OP_INSERT, KEY_A_NUL,  32'hA5A5_A5A5, 1'b1);
      send_request(OP_INSERT, KEY_A,      32'h0000_0001, 1'b0);
      send_request(OP_FIND,   KEY_AB,     '0,           1'b0);
      send_request(OP_FIND,   KEY_AC,     '0,           1'b0);
      send_request(OP_INSERT, KEY_AB,     32'hDEAD_BEEF, 1'b0);
      send_request(OP_INSERT, KEY_AB,     32'h55AA_55AA, 1'b1);
      send_request(OP_FIND,   KEY_AB,     '1,           1'b1);
      send_request(OP_UNUSED, KEY_AB,     32'h0F0F_0F0F, 1'b1);
      send_request(OP_REMOVE, KEY_A_NUL,  '1,           1'b1);
      send_request(OP_REMOVE, KEY_A_NUL,  '0,           1'b0);
      send_request(OP_REMOVE, '1,         '0,           1'b0);
      send_request(OP_REMOVE, '0,         '0,           1'b0);
      send_request(OP_FIND,   '1,         '0,           1'b0);
      send_request(OP_INSERT, KEY_TOPBIT, 32'h8000_0001, 1'b1);
      send_request(OP_FIND,   KEY_TOPBIT, '0,           1'b0);

      // Alternate fill and drain phases so the count sweeps from empty to full
      filling   = 1'b1;
      mode_left = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (mode_left == 0) begin
            filling     = (n == 0) ? 1'b1 : !filling;
            mode_left   = $urandom_range(60, 200);
            steady_send = ($urandom_range(0, 3) == 0);
         end
         mode_left--;
         r = $urandom_range(0, 99);
         if (filling)
            op = (r < 70) ? OP_INSERT : (r < 85) ? OP_FIND : (r < 95) ? OP_REMOVE : OP_UNUSED;
         else
            op = (r < 12) ? OP_INSERT : (r < 30) ? OP_FIND : (r < 95) ? OP_REMOVE : OP_UNUSED;
         case (op)
            OP_REMOVE: stored_pct = 70;
            OP_FIND:   stored_pct = 50;
            default:   stored_pct = 25;
         endcase
         send_request(op, choose_key(stored_pct), choose_value(), 1'($urandom_range(0, 1)));
      end
      req_chan.valid <= 1'b0;

      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (shadow.failures == 0 && shadow.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
